[src/lie_pkg.sv]
// Shared types and constants for the Lagrange interpolation evaluator.
// No dependencies; lie_dp, lie_ctrl and the top level use this package.
package lie_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 10;
  localparam int VAL_W          = 48;
  localparam int STATUS_W       = 2;
  localparam int CHUNK_W        = 16;
  localparam int CHUNK_IW       = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_EVAL   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DUP = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RI,
    S_DUP_LI,
    S_DUP_RJ,
    S_DUP_CJ,
    S_EV_RI,
    S_EV_LI,
    S_EV_RJ,
    S_EV_LJ,
    S_DIV,
    S_MUL,
    S_TERM,
    S_SUM,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                load_t;
    logic                clear_sum;
    logic                load_i;
    logic                load_j;
    logic                div_step;
    logic                mul_step;
    logic [CHUNK_IW-1:0] chunk;
    logic                term_done;
    logic                sum_add;
    logic                out_load;
    logic                out_dup;
  } cmd_t;

  typedef struct packed {
    logic x_eq;
  } sts_t;

endpackage

[src/lie_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lie_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/lie_dp.sv]
// Datapath: serial divider, chunked multiplier, term and sum accumulation, output register.
// Depends on lie_pkg; driven by lie_ctrl through lie_pkg::cmd_t.
module lie_dp #(
  parameter int FRAC_BITS = lie_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lie_pkg::cmd_t                   cmd_i,
  output lie_pkg::sts_t                   sts_o,
  input  logic [lie_pkg::COORD_W-1:0]     eval_x_i,
  input  logic [2*lie_pkg::COORD_W-1:0]   rdata_i,
  output logic [lie_pkg::VAL_W-1:0]       value_o,
  output logic [lie_pkg::STATUS_W-1:0]    status_o
);

  localparam int CW  = lie_pkg::COORD_W;
  localparam int VW  = lie_pkg::VAL_W;
  localparam int DW  = CW + FRAC_BITS;
  localparam int PW  = VW + DW;
  localparam int NCH = (DW + lie_pkg::CHUNK_W - 1) / lie_pkg::CHUNK_W;
  localparam int QPW = NCH * lie_pkg::CHUNK_W;
  localparam int MW  = PW - FRAC_BITS;

  logic [CW-1:0]        t_q, xi_q;
  logic signed [VW-1:0] term_q, term_d, sum_q, sum_d;
  logic                 sat_q, sat_d;
  logic [CW:0]          rem_q, rem_d;
  logic [DW-1:0]        quo_q, quo_d;
  logic [CW-1:0]        den_q;
  logic [VW-1:0]        tmag_q;
  logic                 pneg_q;
  logic [PW-1:0]        acc_q, acc_d;
  logic [VW-1:0]        value_q;
  logic [lie_pkg::STATUS_W-1:0] status_q;

  logic [CW-1:0]        rx, ry;
  logic signed [CW:0]   num_s, den_s;
  logic [CW-1:0]        num_mag, den_mag;
  logic [CW:0]          rem_sh;
  logic                 ge;
  logic [QPW-1:0]       qpad;
  logic [lie_pkg::CHUNK_W-1:0] chunk;
  logic [VW+lie_pkg::CHUNK_W-1:0] pp;
  logic [MW-1:0]        m, lim;
  logic [VW-1:0]        mag;
  logic                 over;
  logic signed [VW:0]   s_ext;

  assign rx = rdata_i[CW-1:0];
  assign ry = rdata_i[2*CW-1:CW];
  assign sts_o.x_eq = (rx == xi_q);

  always_comb begin
    num_s   = $signed({1'b0, t_q}) - $signed({1'b0, rx});
    den_s   = $signed({1'b0, xi_q}) - $signed({1'b0, rx});
    num_mag = num_s[CW] ? CW'(-num_s) : num_s[CW-1:0];
    den_mag = den_s[CW] ? CW'(-den_s) : den_s[CW-1:0];

    rem_sh  = {rem_q[CW-1:0], quo_q[DW-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_d   = ge ? rem_sh - {1'b0, den_q} : rem_sh;
    quo_d   = {quo_q[DW-2:0], ge};

    qpad    = QPW'(quo_q);
    chunk   = qpad[lie_pkg::CHUNK_W*cmd_i.chunk +: lie_pkg::CHUNK_W];
    pp      = tmag_q * chunk;
    acc_d   = acc_q + (PW'(pp) << (lie_pkg::CHUNK_W * cmd_i.chunk));

    // truncate the product toward zero, then clamp the magnitude to the 48-bit range
    m       = acc_q[PW-1:FRAC_BITS];
    lim     = pneg_q ? (MW'(1) << (VW-1)) : ((MW'(1) << (VW-1)) - MW'(1));
    over    = m > lim;
    mag     = over ? lim[VW-1:0] : m[VW-1:0];
    term_d  = pneg_q ? -$signed(mag) : $signed(mag);

    s_ext   = {sum_q[VW-1], sum_q} + {term_q[VW-1], term_q};
    if (s_ext[VW] != s_ext[VW-1]) begin
      sum_d = s_ext[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sum_d = s_ext[VW-1:0];
    end

    sat_d = sat_q;
    if (cmd_i.term_done && over) begin
      sat_d = 1'b1;
    end
    if (cmd_i.sum_add && (s_ext[VW] != s_ext[VW-1])) begin
      sat_d = 1'b1;
    end
    if (cmd_i.clear_sum) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_t) begin
      t_q <= eval_x_i;
    end
    if (cmd_i.clear_sum) begin
      sum_q <= '0;
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_d;
    end
    if (cmd_i.load_i) begin
      xi_q   <= rx;
      term_q <= VW'({ry, {FRAC_BITS{1'b0}}});
    end else if (cmd_i.term_done) begin
      term_q <= term_d;
    end
    if (cmd_i.load_j) begin
      quo_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      den_q  <= den_mag;
      tmag_q <= term_q[VW-1] ? VW'(-term_q) : term_q;
      pneg_q <= term_q[VW-1] ^ (num_s[CW] ^ den_s[CW]);
      acc_q  <= '0;
    end else begin
      if (cmd_i.div_step) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
      end
      if (cmd_i.mul_step) begin
        acc_q <= acc_d;
      end
    end
    if (cmd_i.out_load) begin
      value_q  <= cmd_i.out_dup ? '0 : sum_q;
      status_q <= cmd_i.out_dup ? lie_pkg::ST_DUP : (sat_q ? lie_pkg::ST_SAT : lie_pkg::ST_OK);
    end
  end

  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

[src/lie_ctrl.sv]
// Controller: opcode handling, point count, loop counters and sequencing of the datapath.
// Depends on lie_pkg; issues lie_pkg::cmd_t to lie_dp.
module lie_ctrl #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lie_pkg::FRAC_BITS_DEF,
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lie_pkg::op_e    opcode_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            we_o,
  output logic [AW-1:0]   waddr_o,
  output logic [AW-1:0]   raddr_o,
  output lie_pkg::cmd_t   cmd_o,
  input  lie_pkg::sts_t   sts_i
);

  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int DW   = lie_pkg::COORD_W + FRAC_BITS;
  localparam int DCW  = $clog2(DW);
  localparam int NCH  = (DW + lie_pkg::CHUNK_W - 1) / lie_pkg::CHUNK_W;

  lie_pkg::state_e state_q, state_d;
  logic [CNTW-1:0] count_q, count_d, i_q, i_d, j_q, j_d;
  logic [DCW-1:0]  dcnt_q, dcnt_d;
  logic [lie_pkg::CHUNK_IW-1:0] kcnt_q, kcnt_d;
  logic            dup_q, dup_d;
  logic            oval_q, oval_d;
  logic            accept;

  assign in_ready_o  = (state_q == lie_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = oval_q;

  // next state and counters
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    dcnt_d  = dcnt_q;
    kcnt_d  = kcnt_q;
    dup_d   = dup_q;
    unique case (state_q)
      lie_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            lie_pkg::OP_APPEND: begin
              if (count_q < CNTW'(MAX_POINTS)) begin
                count_d = count_q + 1'b1;
              end
            end
            lie_pkg::OP_CLEAR: count_d = '0;
            lie_pkg::OP_EVAL: begin
              dup_d = 1'b0;
              i_d   = '0;
              state_d = (count_q == '0) ? lie_pkg::S_OUT : lie_pkg::S_DUP_RI;
            end
            default: ;
          endcase
        end
      end
      lie_pkg::S_DUP_RI: begin
        if ((i_q + 1'b1) >= count_q) begin
          i_d     = '0;
          state_d = lie_pkg::S_EV_RI;
        end else begin
          j_d     = i_q + 1'b1;
          state_d = lie_pkg::S_DUP_LI;
        end
      end
      lie_pkg::S_DUP_LI: state_d = lie_pkg::S_DUP_RJ;
      lie_pkg::S_DUP_RJ: state_d = lie_pkg::S_DUP_CJ;
      lie_pkg::S_DUP_CJ: begin
        if (sts_i.x_eq) begin
          dup_d   = 1'b1;
          state_d = lie_pkg::S_OUT;
        end else if ((j_q + 1'b1) < count_q) begin
          j_d     = j_q + 1'b1;
          state_d = lie_pkg::S_DUP_RJ;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = lie_pkg::S_DUP_RI;
        end
      end
      lie_pkg::S_EV_RI: state_d = lie_pkg::S_EV_LI;
      lie_pkg::S_EV_LI: begin
        j_d     = '0;
        state_d = lie_pkg::S_EV_RJ;
      end
      lie_pkg::S_EV_RJ: begin
        if (j_q == count_q) begin
          state_d = lie_pkg::S_SUM;
        end else if (j_q == i_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = lie_pkg::S_EV_LJ;
        end
      end
      lie_pkg::S_EV_LJ: begin
        dcnt_d  = '0;
        state_d = lie_pkg::S_DIV;
      end
      lie_pkg::S_DIV: begin
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(DW - 1)) begin
          kcnt_d  = '0;
          state_d = lie_pkg::S_MUL;
        end
      end
      lie_pkg::S_MUL: begin
        kcnt_d = kcnt_q + 1'b1;
        if (kcnt_q == lie_pkg::CHUNK_IW'(NCH - 1)) begin
          state_d = lie_pkg::S_TERM;
        end
      end
      lie_pkg::S_TERM: begin
        j_d     = j_q + 1'b1;
        state_d = lie_pkg::S_EV_RJ;
      end
      lie_pkg::S_SUM: begin
        i_d     = i_q + 1'b1;
        state_d = ((i_q + 1'b1) == count_q) ? lie_pkg::S_OUT : lie_pkg::S_EV_RI;
      end
      lie_pkg::S_OUT: begin
        if (!oval_q || out_ready_i) begin
          state_d = lie_pkg::S_IDLE;
        end
      end
      default: state_d = lie_pkg::S_IDLE;
    endcase
  end

  // commands to the datapath and the point store
  always_comb begin
    cmd_o   = '0;
    we_o    = 1'b0;
    waddr_o = count_q[AW-1:0];
    raddr_o = i_q[AW-1:0];
    unique case (state_q)
      lie_pkg::S_IDLE: begin
        if (accept && (opcode_i == lie_pkg::OP_APPEND) && (count_q < CNTW'(MAX_POINTS))) begin
          we_o = 1'b1;
        end
        if (accept && (opcode_i == lie_pkg::OP_EVAL)) begin
          cmd_o.load_t    = 1'b1;
          cmd_o.clear_sum = 1'b1;
        end
      end
      lie_pkg::S_DUP_RI: raddr_o = i_q[AW-1:0];
      lie_pkg::S_DUP_LI: cmd_o.load_i = 1'b1;
      lie_pkg::S_DUP_RJ: raddr_o = j_q[AW-1:0];
      lie_pkg::S_DUP_CJ: ;
      lie_pkg::S_EV_RI:  raddr_o = i_q[AW-1:0];
      lie_pkg::S_EV_LI:  cmd_o.load_i = 1'b1;
      lie_pkg::S_EV_RJ:  raddr_o = j_q[AW-1:0];
      lie_pkg::S_EV_LJ:  cmd_o.load_j = 1'b1;
      lie_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      lie_pkg::S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.chunk    = kcnt_q;
      end
      lie_pkg::S_TERM:   cmd_o.term_done = 1'b1;
      lie_pkg::S_SUM:    cmd_o.sum_add = 1'b1;
      lie_pkg::S_OUT: begin
        cmd_o.out_dup  = dup_q;
        cmd_o.out_load = !oval_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign oval_d = (oval_q && !out_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lie_pkg::S_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      dcnt_q  <= '0;
      kcnt_q  <= '0;
      dup_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
      dcnt_q  <= dcnt_d;
      kcnt_q  <= kcnt_d;
      dup_q   <= dup_d;
      oval_q  <= oval_d;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_load_j_ne_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_j |-> (j_q != i_q) && (j_q < count_q))
    else $error("factor taken for own point or beyond count");

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum_add |-> (i_q < count_q) && (j_q == count_q))
    else $error("term added before its factors were complete");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> oval_q && (state_q == lie_pkg::S_IDLE))
    else $error("result load did not raise output valid");

endmodule

[src/lagrange_interpolation_eval_unit.sv]
// Top level of the Lagrange interpolation evaluator: stream ports, point store, control, datapath.
// Depends on lie_pkg, lie_ram, lie_ctrl and lie_dp.
//
//   channel  | dir | handshake                    | payload
//   s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[31:0]: opcode, point_x, point_y, eval_x
//   m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[55:0]: value, status
//
// Append and clear are handled in the idle state. Evaluate over n >= 1 points runs the
// duplicate scan, then the terms, with D = 10+FRAC_BITS radix-2 divider steps and
// NCH = ceil(D/16) passes of the shared 48x16 multiplier per factor, then loads the result.
// A duplicate abscissa ends the scan early; an empty store goes straight to loading its
// result. No clearing pass after reset. Input is taken only while the controller is idle;
// a finished result waits in the output register, and a following evaluate holds in its
// last state until it leaves.
module lagrange_interpolation_eval_unit #(
  parameter int MAX_POINTS = lie_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = lie_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // opcode[1:0], point_x[11:2], point_y[21:12], eval_x[31:22]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // value[47:0], status[49:48], zero[55:50]
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = lie_pkg::COORD_W;

  lie_pkg::cmd_t cmd;
  lie_pkg::sts_t sts;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [2*CW-1:0] rdata;
  logic [lie_pkg::VAL_W-1:0]    value;
  logic [lie_pkg::STATUS_W-1:0] status;

  lie_ram #(
    .WIDTH (2*CW),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata[21:2]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lie_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (lie_pkg::op_e'(s_axis_tdata[1:0])),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .we_o        (we),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lie_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .eval_x_i (s_axis_tdata[31:22]),
    .rdata_i  (rdata),
    .value_o  (value),
    .status_o (status)
  );

  assign m_axis_tdata = {6'd0, status, value};

endmodule
